### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### rtl/nlcg_pkg.sv
`timescale 1ns / 1ps

package nlcg_pkg;

  // Byte codes
  localparam logic [7:0] CHR_NEWLINE = 8'd10;
  localparam logic [7:0] CHR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHR_STAR    = 8'h2A;

  // Sentence prefixes, first character in the top byte
  localparam int unsigned PREFIX_LEN = 6;
  localparam logic [8*PREFIX_LEN-1:0] PFX_GGA = "$GPGGA";
  localparam logic [8*PREFIX_LEN-1:0] PFX_GSA = "$GPGSA";
  localparam logic [8*PREFIX_LEN-1:0] PFX_RMC = "$GPRMC";

  localparam int unsigned GROUP_LINES = 3;
  localparam logic [8:0]  HEX_MAX     = 9'd511;

  // Sentence kind codes
  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_GGA   = 2'd1,
    KIND_GSA   = 2'd2,
    KIND_RMC   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] sentence_kind;
    logic       checksum_ok;
    logic [1:0] line_in_group;
    logic       group_done;
    logic       group_valid;
  } out_item_t;

  // Per-line parse state
  typedef struct packed {
    logic       line_started;
    logic [2:0] prefix_position;
    logic [2:0] prefix_match_flags;
    logic       star_seen;
    logic [7:0] xor_accumulator;
    logic       high_byte_parity;
    logic [8:0] hex_value;
    logic       hex_digit_seen;
    logic       hex_bad;
    logic       trailing_space_seen;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    line_started:        1'b0,
    prefix_position:     3'd0,
    prefix_match_flags:  3'b111,
    star_seen:           1'b0,
    xor_accumulator:     8'd0,
    high_byte_parity:    1'b0,
    hex_value:           9'd0,
    hex_digit_seen:      1'b0,
    hex_bad:             1'b0,
    trailing_space_seen: 1'b0
  };

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
  endfunction

  // Hex digit decode; valid flag in the top bit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, 4'(b - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(b - 8'h61 + 8'd10)};
      [8'h41:8'h46]: r = {1'b1, 4'(b - 8'h41 + 8'd10)};
      default:       r = '0;
    endcase
    return r;
  endfunction

  // Character of a prefix at a position below PREFIX_LEN
  function automatic logic [7:0] prefix_char(input logic [8*PREFIX_LEN-1:0] text,
                                             input logic [2:0] pos);
    logic [2:0] idx;
    idx = 3'(PREFIX_LEN - 1) - pos;
    return text[8*idx +: 8];
  endfunction

endpackage

### rtl/nmea_line_checksum_grouper.sv
`timescale 1ns / 1ps
// NMEA sentence checksum checker with three-line grouping.
//
// in_*  : one stream byte per item (byte_value, stream_end), valid/ready.
// out_* : one result item per closed non-empty line, valid/ready.
// A line closes on a newline byte or on an item with stream_end set; the
// latter also drops any partial group once its line has been counted.
//
// Output: a result is registered into the result register, or into the skid
// register while a result still waits, when the item closing its line is
// accepted. Throughput: one byte per cycle while in_ready is high; the line
// parser and group tracker are a single registered stage updated per accept.
// Stalls: a two-entry output (result register plus skid register) lets the
// block keep taking bytes while one result waits; in_ready drops only when
// both entries are full.
// Reset (rst_n low, synchronous): parser cleared, group position zero,
// output entries empty.

`include "assert_macros.svh"

module nmea_line_checksum_grouper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nlcg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nlcg_pkg::out_item_t out_data
);

  import nlcg_pkg::*;

  line_state_t line_r, line_nxt, line_upd;
  logic [1:0]  group_count_r, group_count_nxt;
  logic        group_good_r, group_good_nxt;
  logic        out_valid_r, skid_valid_r;
  out_item_t   out_data_r, skid_data_r, res;
  logic        res_valid;
  logic        accept, push, pop;
  logic [7:0]  b;
  logic        first, is_nl, do_close;
  logic [4:0]  hd;
  logic [2:0]  flags_mask;
  kind_t       kind;
  logic        ok, good, done;
  logic [1:0]  pos;

  assign accept = in_valid && in_ready;
  assign b      = in_data.byte_value;
  assign is_nl  = (b == CHR_NEWLINE);
  assign first  = !line_r.line_started;
  assign hd     = hex_digit(b);

  // Prefix compare against the three known sentence heads
  always_comb begin
    flags_mask[0] = (prefix_char(PFX_GGA, line_r.prefix_position) == b);
    flags_mask[1] = (prefix_char(PFX_GSA, line_r.prefix_position) == b);
    flags_mask[2] = (prefix_char(PFX_RMC, line_r.prefix_position) == b);
  end

  // Consume one non-newline byte
  always_comb begin
    line_upd = line_r;
    if (!(first && is_space(b))) begin
      line_upd.line_started = 1'b1;
      if (line_r.prefix_position < 3'(PREFIX_LEN)) begin
        line_upd.prefix_match_flags = line_r.prefix_match_flags & flags_mask;
        line_upd.prefix_position    = line_r.prefix_position + 3'd1;
      end
      if (first) begin
        if (b != CHR_DOLLAR) line_upd.hex_bad = 1'b1;
      end else if (!line_r.star_seen) begin
        if (b == CHR_STAR) begin
          line_upd.star_seen = 1'b1;
        end else begin
          line_upd.xor_accumulator  = line_r.xor_accumulator ^ b;
          line_upd.high_byte_parity = line_r.high_byte_parity ^ b[7];
        end
      end else if (is_space(b)) begin
        line_upd.trailing_space_seen = 1'b1;
      end else if (line_r.trailing_space_seen || !hd[4]) begin
        line_upd.hex_bad = 1'b1;
      end else begin
        // saturate once any of the top four bits would shift out
        if (line_r.hex_value[8:5] != 4'd0) line_upd.hex_value = HEX_MAX;
        else line_upd.hex_value = {line_r.hex_value[4:0], hd[3:0]};
        line_upd.hex_digit_seen = 1'b1;
      end
    end
    if (is_nl) line_upd = line_r;
  end

  // Line close and group tracking
  always_comb begin
    kind = KIND_OTHER;
    if (line_upd.prefix_position >= 3'(PREFIX_LEN)) begin
      if (line_upd.prefix_match_flags[0])      kind = KIND_GGA;
      else if (line_upd.prefix_match_flags[1]) kind = KIND_GSA;
      else if (line_upd.prefix_match_flags[2]) kind = KIND_RMC;
    end
    ok = !line_upd.hex_bad && line_upd.star_seen && line_upd.hex_digit_seen &&
         !line_upd.high_byte_parity &&
         (line_upd.hex_value == {1'b0, line_upd.xor_accumulator});
    pos  = group_count_r;
    good = group_good_r && ok && (kind == kind_t'(pos + 2'd1));
    done = (pos >= 2'(GROUP_LINES - 1));

    do_close  = is_nl || in_data.stream_end;
    res_valid = do_close && line_upd.line_started;

    res.sentence_kind = kind;
    res.checksum_ok   = ok;
    res.line_in_group = pos;
    res.group_done    = done;
    res.group_valid   = done && good;

    line_nxt        = do_close ? LINE_CLEAR : line_upd;
    group_count_nxt = group_count_r;
    group_good_nxt  = group_good_r;
    if (res_valid) begin
      group_count_nxt = done ? 2'd0 : pos + 2'd1;
      group_good_nxt  = done ? 1'b1 : good;
    end
    if (in_data.stream_end) begin
      group_count_nxt = 2'd0;
      group_good_nxt  = 1'b1;
    end
  end

  // Output register with skid entry
  assign in_ready  = !skid_valid_r;
  assign push      = accept && res_valid;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r        <= LINE_CLEAR;
      group_count_r <= 2'd0;
      group_good_r  <= 1'b1;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        line_r        <= line_nxt;
        group_count_r <= group_count_nxt;
        group_good_r  <= group_good_nxt;
      end
      if (skid_valid_r) begin
        if (pop) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (push && out_valid_r && !out_ready) begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end else if (push) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Checks
  `ASSERT_IMPL(a_skid_needs_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `ASSERT_CLK(a_group_pos_range, group_count_r != 2'd3, "group position out of range")
  `ASSERT_IMPL(a_valid_only_done, out_valid_r && !out_data_r.group_done,
               !out_data_r.group_valid, "group_valid without group_done")
  `ASSERT_CLK(a_prefix_pos_range, line_r.prefix_position <= 3'(PREFIX_LEN),
              "prefix position past six")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nlcg_pkg::*;

  // Whitespace bytes trimmed around a sentence
  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_VT    = 8'd11;
  localparam logic [7:0] CHR_FF    = 8'd12;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_SPACE = 8'd32;

  localparam int RANDOM_ITEMS = 550;
  localparam int DIR_ROWS     = 24;
  localparam int LONG_HOLD    = 80;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int REPORT_MAX   = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  nmea_line_checksum_grouper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Sentence parse state kept by the predictor
  typedef struct packed {
    logic       started;
    logic [2:0] pfx_pos;
    logic [2:0] pfx_hits;
    logic       star;
    logic [7:0] sum;
    logic       hi_odd;
    logic [8:0] hexv;
    logic       hex_any;
    logic       bad;
    logic       trail;
  } sentence_state_t;

  localparam sentence_state_t SENTENCE_IDLE = {1'b0, 3'd0, 3'b111, 1'b0, 8'd0, 1'b0,
                                               9'd0, 1'b0, 1'b0, 1'b0};

  // Directed stimulus row; lit marks a result typed in by hand
  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       lit;
    out_item_t  res;
  } dir_row_t;

  sentence_state_t cur;
  logic [1:0]      grp_pos;
  logic            grp_ok;

  out_item_t expected_results [$];
  int        mismatches;
  int        cycle_cnt;
  int        handled_items;
  int        send_idle_pct;
  int        stall_pct;
  int        hold_req;
  int        hold_seen;
  int        hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit is_white(input logic [7:0] b);
    return (b == CHR_TAB) || (b == CHR_VT) || (b == CHR_FF) || (b == CHR_CR) ||
           (b == CHR_SPACE);
  endfunction

  function automatic int hex_val(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [8*PREFIX_LEN-1:0] text,
                                             input int pos);
    return text[8*(PREFIX_LEN-1-pos) +: 8];
  endfunction

  // Fold one non-newline byte into the sentence state
  function automatic void feed_byte(input logic [7:0] b);
    bit first;
    int d;
    int v;
    first = !cur.started;
    if (first) begin
      if (is_white(b)) return;
      cur.started = 1'b1;
    end
    if (cur.pfx_pos < PREFIX_LEN) begin
      if (prefix_byte(PFX_GGA, cur.pfx_pos) != b) cur.pfx_hits[0] = 1'b0;
      if (prefix_byte(PFX_GSA, cur.pfx_pos) != b) cur.pfx_hits[1] = 1'b0;
      if (prefix_byte(PFX_RMC, cur.pfx_pos) != b) cur.pfx_hits[2] = 1'b0;
      cur.pfx_pos = cur.pfx_pos + 3'd1;
    end
    if (first) begin
      if (b != CHR_DOLLAR) cur.bad = 1'b1;
      return;
    end
    // checksum span up to the first star
    if (!cur.star) begin
      if (b == CHR_STAR) begin
        cur.star = 1'b1;
      end else begin
        cur.sum = cur.sum ^ b;
        if (b[7]) cur.hi_odd = ~cur.hi_odd;
      end
      return;
    end
    // hex field, whitespace only as a tail
    if (is_white(b)) begin
      cur.trail = 1'b1;
      return;
    end
    if (cur.trail) begin
      cur.bad = 1'b1;
      return;
    end
    d = hex_val(b);
    if (d < 0) begin
      cur.bad = 1'b1;
      return;
    end
    v = int'(cur.hexv) * 16 + d;
    cur.hexv = (v > int'(HEX_MAX)) ? HEX_MAX : 9'(v);
    cur.hex_any = 1'b1;
  endfunction

  // Close the current sentence; returns 1 when a result item is due
  function automatic bit close_sentence(output out_item_t r);
    kind_t k;
    logic  ok;
    logic  good;
    logic  done;
    r = '0;
    if (!cur.started) begin
      cur = SENTENCE_IDLE;
      return 1'b0;
    end
    k = KIND_OTHER;
    if (cur.pfx_pos >= PREFIX_LEN) begin
      if (cur.pfx_hits[0]) k = KIND_GGA;
      else if (cur.pfx_hits[1]) k = KIND_GSA;
      else if (cur.pfx_hits[2]) k = KIND_RMC;
    end
    ok = !cur.bad && cur.star && cur.hex_any && !cur.hi_odd && (cur.hexv == {1'b0, cur.sum});
    done = (grp_pos >= 2'(GROUP_LINES - 1));
    good = grp_ok && ok && (k == kind_t'(grp_pos + 2'd1));
    r.sentence_kind = k;
    r.checksum_ok   = ok;
    r.line_in_group = grp_pos;
    r.group_done    = done;
    r.group_valid   = done && good;
    if (done) begin
      grp_pos = 2'd0;
      grp_ok  = 1'b1;
    end else begin
      grp_pos = grp_pos + 2'd1;
      grp_ok  = good;
    end
    cur = SENTENCE_IDLE;
    return 1'b1;
  endfunction

  function automatic void predict_nmea_byte(input in_item_t it, output bit have,
                                            output out_item_t r);
    r = '0;
    have = 1'b0;
    if (it.byte_value == CHR_NEWLINE) have = close_sentence(r);
    else feed_byte(it.byte_value);
    // stream end: close, count, then drop the partial group
    if (it.stream_end) begin
      if (!have) have = close_sentence(r);
      grp_pos = 2'd0;
      grp_ok  = 1'b1;
    end
  endfunction

  function automatic dir_row_t dir_row(input int i);
    dir_row_t r;
    r = '0;
    case (i)
      // shortest good sentence
      0:  r.b = CHR_DOLLAR;
      1:  r.b = CHR_STAR;
      2:  r.b = "0";
      3:  begin
        r.b = CHR_NEWLINE; r.lit = 1'b1; r.res = {KIND_OTHER, 1'b1, 2'd0, 1'b0, 1'b0};
      end
      // no leading dollar
      4:  r.b = "x";
      5:  begin
        r.b = CHR_NEWLINE; r.lit = 1'b1; r.res = {KIND_OTHER, 1'b0, 2'd1, 1'b0, 1'b0};
      end
      // star with nothing after it, third of a group
      6:  r.b = CHR_DOLLAR;
      7:  r.b = CHR_STAR;
      8:  begin
        r.b = CHR_NEWLINE; r.lit = 1'b1; r.res = {KIND_OTHER, 1'b0, 2'd2, 1'b1, 1'b0};
      end
      // top byte value closing the stream
      9:  begin
        r.b = 8'hFF; r.e = 1'b1; r.lit = 1'b1;
        r.res = {KIND_OTHER, 1'b0, 2'd0, 1'b0, 1'b0};
      end
      // whitespace-only line gives nothing
      10: r.b = CHR_SPACE;
      11: r.b = CHR_NEWLINE;
      // odd count of high bytes forces a mismatch
      12: r.b = CHR_DOLLAR;
      13: r.b = 8'h80;
      14: r.b = CHR_STAR;
      15: r.b = "8";
      16: r.b = "0";
      17: begin
        r.b = CHR_NEWLINE; r.lit = 1'b1; r.res = {KIND_OTHER, 1'b0, 2'd0, 1'b0, 1'b0};
      end
      // non-hex digit, newline together with stream end
      18: r.b = CHR_DOLLAR;
      19: r.b = CHR_STAR;
      20: r.b = "g";
      21: begin
        r.b = CHR_NEWLINE; r.e = 1'b1; r.lit = 1'b1;
        r.res = {KIND_OTHER, 1'b0, 2'd1, 1'b0, 1'b0};
      end
      // zero byte as a whole line
      22: r.b = 8'h00;
      default: r.b = CHR_NEWLINE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_white();
    case ($urandom_range(4))
      0:       return CHR_TAB;
      1:       return CHR_VT;
      2:       return CHR_FF;
      3:       return CHR_CR;
      default: return CHR_SPACE;
    endcase
  endfunction

  // Hex digit character, upper or lower case at random
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    if ($urandom_range(1)) return 8'("A") + 8'(n) - 8'd10;
    return 8'("a") + 8'(n) - 8'd10;
  endfunction

  // Offer one byte, wait for acceptance, then book the expected result
  task automatic send_byte(input logic [7:0] b, input logic e, input bit lit,
                           input out_item_t lit_res);
    bit        have;
    out_item_t res;
    in_item_t  it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it = {b, e};
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (cur.started || !is_white(b) || e) handled_items++;
    predict_nmea_byte(it, have, res);
    if (lit) expected_results.push_back(lit_res);
    else if (have) expected_results.push_back(res);
  endtask

  // Mostly well-formed sentences following the group order, with some flaws
  task automatic send_sentence();
    logic [7:0] txt [$];
    logic [7:0] sum;
    logic [7:0] chk;
    logic [7:0] c;
    logic [1:0] want;
    int         i;
    int         n;
    int         flaw;
    int         tail;
    bit         fin;
    txt = {};
    sum = 8'd0;
    fin = 1'b0;
    if ($urandom_range(99) < 15) repeat ($urandom_range(2, 1)) txt.push_back(pick_white());
    want = ($urandom_range(99) < 75) ? 2'(grp_pos + 2'd1) : 2'($urandom_range(3));
    txt.push_back(CHR_DOLLAR);
    n = (want == KIND_OTHER) ? $urandom_range(PREFIX_LEN - 1) : PREFIX_LEN - 1;
    for (i = 1; i <= n; i++) begin
      case (want)
        KIND_GGA: c = prefix_byte(PFX_GGA, i);
        KIND_GSA: c = prefix_byte(PFX_GSA, i);
        KIND_RMC: c = prefix_byte(PFX_RMC, i);
        default:  c = (i < 3) ? prefix_byte(PFX_GGA, i) : 8'($urandom_range("Z", "A"));
      endcase
      txt.push_back(c);
      sum = sum ^ c;
    end
    // body, printable with the odd high byte
    n = $urandom_range(6);
    for (i = 0; i < n; i++) begin
      c = 8'($urandom_range(8'h7E, 8'h20));
      if (c == CHR_STAR) c = ",";
      txt.push_back(c);
      sum = sum ^ c;
    end
    if ($urandom_range(99) < 8) begin
      c = 8'($urandom_range(255, 128));
      txt.push_back(c);
      sum = sum ^ c;
      if ($urandom_range(1)) begin
        c = 8'($urandom_range(255, 128));
        txt.push_back(c);
        sum = sum ^ c;
      end
    end
    // checksum field, broken in various ways now and then
    flaw = $urandom_range(99);
    chk = (flaw >= 70 && flaw < 76) ? sum ^ 8'($urandom_range(255, 1)) : sum;
    if (flaw < 76 || flaw >= 80) begin
      txt.push_back(CHR_STAR);
      if (flaw < 76) begin
        txt.push_back(hex_char(chk[7:4]));
        txt.push_back(hex_char(chk[3:0]));
      end else if (flaw < 84) begin
      end else if (flaw < 88) begin
        txt.push_back(hex_char(4'($urandom_range(15))));
        txt.push_back(hex_char(chk[7:4]));
        txt.push_back(hex_char(chk[3:0]));
      end else if (flaw < 92) begin
        txt.push_back(hex_char(chk[7:4]));
        txt.push_back(hex_char(chk[3:0]));
        case ($urandom_range(2))
          0:       txt.push_back(CHR_STAR);
          1:       txt.push_back("z");
          default: txt.push_back(8'($urandom_range(255, 128)));
        endcase
      end else if (flaw < 96) begin
        txt.push_back(hex_char(chk[7:4]));
        txt.push_back(CHR_SPACE);
        txt.push_back(hex_char(chk[3:0]));
      end else begin
        txt.push_back(hex_char(chk[3:0]));
      end
    end
    if ($urandom_range(99) < 15) repeat ($urandom_range(2, 1)) txt.push_back(pick_white());
    if ($urandom_range(99) < 10) txt.push_back(CHR_CR);
    // line ending: newline, newline with stream end, or stream end alone
    tail = $urandom_range(99);
    if (tail < 3) begin
      fin = 1'b1;
    end else begin
      txt.push_back(CHR_NEWLINE);
      fin = (tail < 6);
    end
    for (i = 0; i < txt.size(); i++)
      send_byte(txt[i], fin && (i == txt.size() - 1), 1'b0, '0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 1))
      send_byte(8'($urandom_range(255)), $urandom_range(99) < 3, 1'b0, '0);
  endtask

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind %0d ok %0d pos %0d done %0d valid %0d",
                   out_data.sentence_kind, out_data.checksum_ok, out_data.line_in_group,
                   out_data.group_done, out_data.group_valid);
      end else begin
        want = expected_results.pop_front();
        if (out_data.sentence_kind !== want.sentence_kind ||
            out_data.checksum_ok !== want.checksum_ok ||
            out_data.line_in_group !== want.line_in_group ||
            out_data.group_done !== want.group_done ||
            out_data.group_valid !== want.group_valid) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch: exp kind %0d ok %0d pos %0d done %0d valid %0d",
                     want.sentence_kind, want.checksum_ok, want.line_in_group,
                     want.group_done, want.group_valid);
            $display("          got kind %0d ok %0d pos %0d done %0d valid %0d",
                     out_data.sentence_kind, out_data.checksum_ok,
                     out_data.line_in_group, out_data.group_done,
                     out_data.group_valid);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int       i;
    int       phase;
    int       phase_now;
    bit       hold_done;
    dir_row_t row;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    mismatches    = 0;
    cycle_cnt     = 0;
    handled_items = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 0;
    hold_done     = 1'b0;
    phase         = 0;
    cur           = SENTENCE_IDLE;
    grp_pos       = 2'd0;
    grp_ok        = 1'b1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      send_byte(row.b, row.e, row.lit, row.res);
    end

    // random part in idling phases
    handled_items = 0;
    while (handled_items < RANDOM_ITEMS) begin
      phase_now = (handled_items * 4) / RANDOM_ITEMS;
      if (phase_now > 3) phase_now = 3;
      if (phase_now != phase) begin
        phase = phase_now;
        case (phase)
          1: begin
            send_idle_pct = 54; stall_pct = 0;
            // sender pause until every result is home
            in_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clk);
            @(negedge clk);
          end
          2:       begin send_idle_pct = 0;  stall_pct = 54; end
          default: begin send_idle_pct = 28; stall_pct = 28; end
        endcase
      end
      if (!hold_done && handled_items >= 60) begin
        hold_req++;
        hold_done = 1'b1;
      end
      if ($urandom_range(99) < 80) send_sentence();
      else send_noise();
    end
    in_valid <= 1'b0;

    // drain
    stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
